### hdl/sst_pkg.sv
// Package for the scoped symbol table: sizes, codes and the structs passed
// between the controller and the row of entry cells. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sst_pkg;

	localparam int NUM_ENTRIES = 64;
	localparam int MAX_DEPTH   = 16;
	localparam int KEY_BITS    = 32;
	localparam int INFO_BITS   = 32;

	localparam int FUNC_W      = 2;
	localparam int NAME_W      = 32;
	localparam int INFO_IN_W   = 32;
	localparam int STATUS_W    = 3;
	localparam int DEPTH_OUT_W = 5;

	localparam int KEY_W   = (KEY_BITS < NAME_W) ? KEY_BITS : NAME_W;
	localparam int INFO_W  = (INFO_BITS < INFO_IN_W) ? INFO_BITS : INFO_IN_W;
	localparam int IDX_W   = $clog2(NUM_ENTRIES);
	localparam int ENTRY_W = $clog2(NUM_ENTRIES + 1);
	localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
	localparam int DIDX_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	typedef enum logic [FUNC_W-1:0] {
		FN_ENTER   = 2'd0,
		FN_EXIT    = 2'd1,
		FN_DECLARE = 2'd2,
		FN_LOOKUP  = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK       = 3'd0,
		STS_MISS     = 3'd1,
		STS_FULL     = 3'd2,
		STS_OVERFLOW = 3'd3,
		STS_NO_SCOPE = 3'd4
	} status_t;

	typedef struct packed {
		logic              v;
		logic [KEY_W-1:0]  key;
		logic              hit;
		logic [INFO_W-1:0] info;
	} tok_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] lo;
		logic [ENTRY_W-1:0] hi;
	} rng_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [KEY_W-1:0]  key;
		logic [INFO_W-1:0] info;
	} wr_t;

endpackage
`default_nettype wire

### hdl/sst_in_if.sv
// Command channel of the scoped symbol table: valid/ready plus one command word.
// Depends on sst_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface sst_in_if import sst_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [FUNC_W-1:0]    func;
	logic [NAME_W-1:0]    name_key;
	logic [INFO_IN_W-1:0] info_value;

	modport source (output valid, func, name_key, info_value, input ready);
	modport sink (input valid, func, name_key, info_value, output ready);
endinterface
`default_nettype wire

### hdl/sst_out_if.sv
// Response channel of the scoped symbol table: valid/ready plus one result word.
// Depends on sst_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface sst_out_if import sst_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic [INFO_IN_W-1:0]   info_out;
	logic [DEPTH_OUT_W-1:0] depth_out;

	modport source (output valid, status, info_out, depth_out, input ready);
	modport sink (input valid, status, info_out, depth_out, output ready);
endinterface
`default_nettype wire

### hdl/scoped_symbol_table.sv
// Scoped symbol table: controller plus a row of NUM_ENTRIES entry cells.
// Depends on sst_pkg, sst_in_if, sst_out_if, sst_ctrl and sst_cell.
//
// Usage:
//   cmd carries one command word (func, name_key, info_value); rsp returns
//   one result word (status, info_out, depth_out) per command, in order.
//   Enter, exit, and a declare with no open scope finish at once: the
//   result is valid in the cycle after the accepting edge.
//   Declare and lookup send a search token through the cell row, one cell
//   a cycle; the result goes to a hold register when the token leaves the
//   last cell, then to the output register, and the next command is taken
//   once the controller is back in idle. The row length sets the search time.
//   Entries sit in declaration order, one per cell; closing a scope only
//   moves the fill count back to the scope's start.
//   Reset: the global scope is open, the table is empty, no result pending.
//   Entry contents are not cleared; unused cells are never matched.
//   Stall: the result is held in the output register while rsp.ready is
//   low. A declare or lookup may be accepted and searched meanwhile; an
//   immediate command waits until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module scoped_symbol_table import sst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sst_in_if.sink    cmd,
	sst_out_if.source rsp
);

	tok_t chain [NUM_ENTRIES+1];
	rng_t rng;
	wr_t  wr;

	sst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rsp      (rsp),
		.tok_o    (chain[0]),
		.tok_last (chain[NUM_ENTRIES]),
		.rng      (rng),
		.wr       (wr)
	);

	for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
		sst_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (IDX_W'(g)),
			.rng    (rng),
			.wr     (wr),
			.tok_i  (chain[g]),
			.tok_o  (chain[g+1])
		);
	end

endmodule
`default_nettype wire

### hdl/sst_cell.sv
// One entry cell of the symbol row: holds one key/info pair and passes the
// search token to its neighbor each cycle. Depends on sst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sst_cell import sst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  rng_t             rng,
	input  wr_t              wr,
	input  tok_t             tok_i,
	output tok_t             tok_o
);

	logic [KEY_W-1:0]  entry_key_q;
	logic [INFO_W-1:0] entry_info_q;
	logic              tok_v_q;
	logic [KEY_W-1:0]  tok_key_q;
	logic              tok_hit_q;
	logic [INFO_W-1:0] tok_info_q;
	logic              live;
	logic              match;

	always_comb begin
		live  = (ENTRY_W'(idx) >= rng.lo) && (ENTRY_W'(idx) < rng.hi);
		match = tok_i.v && live && (entry_key_q == tok_i.key);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_v_q <= 1'b0;
		end else begin
			tok_v_q <= tok_i.v;
		end
	end

	// later entries are newer: a match overrides what the token carries
	always_ff @(posedge clk) begin
		tok_key_q  <= tok_i.key;
		tok_hit_q  <= tok_i.hit | match;
		tok_info_q <= match ? entry_info_q : tok_i.info;
		if (wr.en && (wr.idx == idx)) begin
			entry_key_q  <= wr.key;
			entry_info_q <= wr.info;
		end
	end

	assign tok_o = '{v: tok_v_q, key: tok_key_q, hit: tok_hit_q, info: tok_info_q};

endmodule
`default_nettype wire

### hdl/sst_ctrl.sv
// Controller of the scoped symbol table: scope stack, fill count, command
// decode, token launch and the response register. Depends on sst_pkg and the
// channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
module sst_ctrl import sst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sst_in_if.sink    cmd,
	sst_out_if.source rsp,
	output tok_t      tok_o,
	input  tok_t      tok_last,
	output rng_t      rng,
	output wr_t       wr
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                 state_q;
	logic [ENTRY_W-1:0]     fill_q;
	logic [DEPTH_W-1:0]     depth_q;
	logic [ENTRY_W-1:0]     start_q [MAX_DEPTH];
	logic                   tok_v_q;
	logic [KEY_W-1:0]       tok_key_q;
	func_t                  op_q;
	logic [INFO_W-1:0]      info_q;
	rng_t                   rng_q;
	status_t                hold_status_q;
	logic [INFO_W-1:0]      hold_info_q;
	logic                   out_v_q;
	status_t                out_status_q;
	logic [INFO_IN_W-1:0]   out_info_q;
	logic [DEPTH_OUT_W-1:0] out_depth_q;

	func_t              fn;
	logic               out_free;
	logic               scan_op;
	logic               accept;
	logic               overflow;
	logic [DIDX_W-1:0]  top_idx;
	logic [DIDX_W-1:0]  depth_idx;
	status_t            imm_status;
	logic [DEPTH_W-1:0] imm_depth;
	status_t            scan_status;
	logic [INFO_W-1:0]  scan_info;
	logic               do_write;
	logic               scan_end;

	always_comb begin
		fn        = func_t'(cmd.func);
		out_free  = !out_v_q || rsp.ready;
		scan_op   = (fn == FN_LOOKUP) || ((fn == FN_DECLARE) && (depth_q != '0));
		cmd.ready = (state_q == ST_IDLE) && (scan_op || out_free);
		accept    = cmd.valid && cmd.ready;
		overflow  = depth_q >= DEPTH_W'(MAX_DEPTH);
		top_idx   = DIDX_W'(depth_q - DEPTH_W'(1));
		depth_idx = DIDX_W'(depth_q);
		scan_end  = (state_q == ST_SCAN) && tok_last.v;
	end

	always_comb begin
		imm_status = STS_OK;
		imm_depth  = depth_q;
		unique case (fn)
			FN_ENTER: begin
				if (overflow) begin
					imm_status = STS_OVERFLOW;
				end else begin
					imm_depth = depth_q + DEPTH_W'(1);
				end
			end
			FN_EXIT: begin
				if (depth_q == '0) begin
					imm_status = STS_NO_SCOPE;
				end else begin
					imm_depth = depth_q - DEPTH_W'(1);
				end
			end
			FN_DECLARE: imm_status = STS_NO_SCOPE;
			default: imm_status = STS_OK;
		endcase
	end

	always_comb begin
		scan_status = STS_OK;
		scan_info   = '0;
		do_write    = 1'b0;
		if (op_q == FN_DECLARE) begin
			if (tok_last.hit) begin
				scan_status = STS_MISS;
			end else if (fill_q >= ENTRY_W'(NUM_ENTRIES)) begin
				scan_status = STS_FULL;
			end else begin
				do_write = scan_end;
			end
		end else begin
			if (tok_last.hit) begin
				scan_info = tok_last.info;
			end else begin
				scan_status = STS_MISS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			depth_q <= DEPTH_W'(1);
			tok_v_q <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i < MAX_DEPTH; i++) begin
				start_q[i] <= '0;
			end
		end else begin
			tok_v_q <= 1'b0;
			if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (scan_op) begin
							state_q <= ST_SCAN;
							tok_v_q <= 1'b1;
						end else begin
							out_v_q <= 1'b1;
							depth_q <= imm_depth;
						end
						if ((fn == FN_ENTER) && !overflow) begin
							start_q[depth_idx] <= fill_q;
						end
						if ((fn == FN_EXIT) && (depth_q != '0)) begin
							fill_q <= start_q[top_idx];
						end
					end
				end
				ST_SCAN: begin
					if (tok_last.v) begin
						state_q <= ST_DONE;
						if (do_write) begin
							fill_q <= fill_q + ENTRY_W'(1);
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						out_v_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= fn;
			tok_key_q <= cmd.name_key[KEY_W-1:0];
			info_q    <= cmd.info_value[INFO_W-1:0];
			rng_q.lo  <= (fn == FN_DECLARE) ? start_q[top_idx] : '0;
			rng_q.hi  <= fill_q;
			if (!scan_op) begin
				out_status_q <= imm_status;
				out_info_q   <= '0;
				out_depth_q  <= DEPTH_OUT_W'(imm_depth);
			end
		end
		if (scan_end) begin
			hold_status_q <= scan_status;
			hold_info_q   <= scan_info;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_status_q <= hold_status_q;
			out_info_q   <= INFO_IN_W'(hold_info_q);
			out_depth_q  <= DEPTH_OUT_W'(depth_q);
		end
	end

	assign tok_o = '{v: tok_v_q, key: tok_key_q, hit: 1'b0, info: '0};
	assign rng   = rng_q;
	assign wr    = '{en: do_write, idx: fill_q[IDX_W-1:0], key: tok_key_q, info: info_q};

	assign rsp.valid     = out_v_q;
	assign rsp.status    = out_status_q;
	assign rsp.info_out  = out_info_q;
	assign rsp.depth_out = out_depth_q;

`ifndef SYNTHESIS
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(MAX_DEPTH))
		else $error("scope depth beyond limit");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= ENTRY_W'(NUM_ENTRIES))
		else $error("fill count beyond table size");
	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_last.v |-> (state_q == ST_SCAN))
		else $error("search token returned outside a scan");
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && scan_op) |=> ((state_q == ST_SCAN) && tok_v_q))
		else $error("scan did not launch");
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |-> ((op_q == FN_DECLARE) && (fill_q < ENTRY_W'(NUM_ENTRIES))))
		else $error("entry write outside a valid declare");
`endif

endmodule
`default_nettype wire
